@@ rtl/core/crre_pkg.sv @@
// Shared constants and types of the color run region explorer.
package crre_pkg;

   localparam int IMG_WIDTH   = 320;
   localparam int IMG_HEIGHT  = 240;
   localparam int NUM_CLASSES = 16;

   localparam int FRAME_DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
   localparam int PIX_XW      = $clog2(IMG_WIDTH);
   localparam int PIX_YW      = $clog2(IMG_HEIGHT);

   // signed working width of row and column arithmetic
   localparam int COORD_W = 11;
   localparam int PROD_W  = 13;

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   localparam logic [2:0] REG_EXPLORE_STEP = 3'd0;
   localparam logic [2:0] REG_GRID_STEP    = 3'd1;
   localparam logic [2:0] REG_SKIP_OFFSET  = 3'd2;
   localparam logic [2:0] REG_MIN_LEN_LOW  = 3'd3;
   localparam logic [2:0] REG_MIN_LEN_HIGH = 3'd4;
   localparam logic [2:0] REG_GREEN_CLASS  = 3'd5;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_EXPLORE = 1'b1;

   // which sequencer step a run scan returns to
   localparam logic [1:0] RET_RUN  = 2'd0;
   localparam logic [1:0] RET_UP   = 2'd1;
   localparam logic [1:0] RET_DOWN = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

@@ rtl/core/color_run_region_explorer.sv @@
// Color run region explorer: frame store, run scan sequencer and register port.
//
//   channel  signals                          direction  carries
//   req      req_valid/req_ready + fields     in         pixel write or explore item
//   rsp      rsp_valid/rsp_ready + fields     out        one result per explore item
//   csr      psel/penable/pwrite/paddr/...    in/out     six registers at 8*i
//
// A write item stores one in-range pixel. An explore item samples or backtracks
// pixels and explores columns: every pixel goes through the single read port of
// the frame store, and no new item is taken until the explore item has finished.
// Reset is synchronous and restores the registers; the frame store is not cleared.
// A waiting result does not block the next item; a new result waits until the
// previous one has been taken.
module color_run_region_explorer
   import crre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [8:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [3:0]        req_color_class,
   input  logic signed [9:0] req_x_left_bound,
   input  logic [7:0]        req_y_lower_bound,
   input  logic signed [8:0] req_y_upper_bound,
   input  logic              req_force_detailed,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_rejected,
   output logic [11:0]       rsp_region_size,
   output logic [7:0]        rsp_run_end,
   output logic [7:0]        rsp_top_y,
   output logic signed [8:0] rsp_bottom_y,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SC_TEST  = 4'd1;
   localparam logic [3:0] ST_SC_CHK   = 4'd2;
   localparam logic [3:0] ST_BK_TEST  = 4'd3;
   localparam logic [3:0] ST_BK_CHK   = 4'd4;
   localparam logic [3:0] ST_SC_DONE  = 4'd5;
   localparam logic [3:0] ST_RUN_POST = 4'd6;
   localparam logic [3:0] ST_COL_TEST = 4'd7;
   localparam logic [3:0] ST_TOP_CHK  = 4'd8;
   localparam logic [3:0] ST_BOT_RD   = 4'd9;
   localparam logic [3:0] ST_BOT_CHK  = 4'd10;
   localparam logic [3:0] ST_FINISH   = 4'd11;

   // registers
   logic [6:0]  explore_step_ff;
   logic [4:0]  grid_step_ff;
   logic [4:0]  skip_offset_ff;
   logic [63:0] min_len_low_ff;
   logic [63:0] min_len_high_ff;
   logic [3:0]  green_class_ff;
   logic        csr_wr;

   // frame store
   logic [3:0]          frame_mem [0:FRAME_DEPTH-1];
   logic [3:0]          rd_data_ff;
   logic                rd_hit_ff;
   logic [FRAME_AW-1:0] mem_addr;
   logic                mem_we;
   coord_type           rd_x;
   coord_type           rd_y;
   logic                rd_hit;
   logic                pix_match;

   // sequencer
   logic [3:0]  state_ff, state_in;
   coord_type   col_x_ff, col_x_in;
   coord_type   top_ff, top_in;
   coord_type   bot_ff, bot_in;
   coord_type   run_end_ff, run_end_in;
   coord_type   scan_y_ff, scan_y_in;
   coord_type   scan_back_ff, scan_back_in;
   coord_type   scan_lim_ff, scan_lim_in;
   logic        scan_dn_ff, scan_dn_in;
   logic [1:0]  scan_ret_ff, scan_ret_in;
   logic [3:0]  cls_ff, cls_in;
   logic [7:0]  py_ff, py_in;
   coord_type   xmin_ff, xmin_in;
   logic [7:0]  yend_ff, yend_in;
   coord_type   ymin_ff, ymin_in;
   logic        force_ff, force_in;
   logic [11:0] size_ff, size_in;
   logic        rej_ff, rej_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_rej_ff, rsp_rej_in;
   logic [11:0]       rsp_size_ff, rsp_size_in;
   logic [7:0]        rsp_run_end_ff, rsp_run_end_in;
   logic [7:0]        rsp_top_ff, rsp_top_in;
   logic signed [8:0] rsp_bot_ff, rsp_bot_in;

   logic [4:0]  skip_eff;
   logic [6:0]  step_eff;
   coord_type   skip_c;
   coord_type   step_c;
   coord_type   d_skip;
   coord_type   d_unit;
   coord_type   y_delta;
   coord_type   y_sum;
   coord_type   scan_res;
   coord_type   yend_c;
   coord_type   py_c;
   coord_type   run_len;
   logic [7:0]  min_len;
   logic [63:0] min_word;
   logic [PROD_W-1:0] prod;
   logic        accept;

   // ---------------------------------------------------------------- registers
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         explore_step_ff <= 7'd4;
         grid_step_ff    <= 5'd4;
         skip_offset_ff  <= 5'd2;
         min_len_low_ff  <= '0;
         min_len_high_ff <= '0;
         green_class_ff  <= 4'd5;
      end else if (csr_wr) begin
         case (paddr[5:3])
            REG_EXPLORE_STEP: explore_step_ff <= pwdata[6:0];
            REG_GRID_STEP:    grid_step_ff    <= pwdata[4:0];
            REG_SKIP_OFFSET:  skip_offset_ff  <= pwdata[4:0];
            REG_MIN_LEN_LOW:  min_len_low_ff  <= pwdata;
            REG_MIN_LEN_HIGH: min_len_high_ff <= pwdata;
            REG_GREEN_CLASS:  green_class_ff  <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[5:3])
         REG_EXPLORE_STEP: prdata = {{(CSR_DW-7){1'b0}}, explore_step_ff};
         REG_GRID_STEP:    prdata = {{(CSR_DW-5){1'b0}}, grid_step_ff};
         REG_SKIP_OFFSET:  prdata = {{(CSR_DW-5){1'b0}}, skip_offset_ff};
         REG_MIN_LEN_LOW:  prdata = min_len_low_ff;
         REG_MIN_LEN_HIGH: prdata = min_len_high_ff;
         REG_GREEN_CLASS:  prdata = {{(CSR_DW-4){1'b0}}, green_class_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pixel port
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign mem_we = accept && (req_type == REQ_WRITE)
                   && ({1'b0, req_pos_x} < 10'(IMG_WIDTH))
                   && ({1'b0, req_pos_y} < 9'(IMG_HEIGHT))
                   && ({1'b0, req_color_class} < 5'(NUM_CLASSES));

   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_x = coord_type'({{(COORD_W-9){1'b0}}, req_pos_x});
         rd_y = coord_type'({{(COORD_W-8){1'b0}}, req_pos_y});
      end else begin
         rd_x = col_x_ff;
         case (state_ff)
            ST_COL_TEST: rd_y = top_ff;
            ST_BOT_RD:   rd_y = bot_ff;
            default:     rd_y = scan_y_ff;
         endcase
      end
   end

   assign rd_hit = (rd_x >= coord_type'(0)) && (rd_x < coord_type'(IMG_WIDTH))
                   && (rd_y >= coord_type'(0)) && (rd_y < coord_type'(IMG_HEIGHT));

   always_comb begin
      if (rd_hit) begin
         mem_addr = FRAME_AW'(FRAME_AW'(rd_y[PIX_YW-1:0]) * FRAME_AW'(IMG_WIDTH))
                    + FRAME_AW'(rd_x[PIX_XW-1:0]);
      end else begin
         mem_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= req_color_class;
      end
      rd_data_ff <= frame_mem[mem_addr];
      rd_hit_ff  <= rd_hit;
   end

   assign pix_match = rd_hit_ff && (rd_data_ff == cls_ff);

   // ---------------------------------------------------------------- shared datapath
   assign skip_eff = (skip_offset_ff == 5'd0) ? 5'd1 : skip_offset_ff;
   assign step_eff = (explore_step_ff == 7'd0) ? 7'd1 : explore_step_ff;
   assign skip_c   = coord_type'({{(COORD_W-5){1'b0}}, skip_eff});
   assign step_c   = coord_type'({{(COORD_W-7){1'b0}}, step_eff});
   assign d_skip   = scan_dn_ff ? skip_c : -skip_c;
   assign d_unit   = scan_dn_ff ? coord_type'(1) : coord_type'(-1);
   assign yend_c   = coord_type'({{(COORD_W-8){1'b0}}, yend_ff});
   assign py_c     = coord_type'({{(COORD_W-8){1'b0}}, py_ff});

   always_comb begin
      case (state_ff)
         ST_BK_TEST: y_delta = d_unit;
         ST_SC_CHK,
         ST_BK_CHK:  y_delta = pix_match ? d_skip : -d_unit;
         default:    y_delta = d_skip;
      endcase
   end
   assign y_sum = scan_y_ff + y_delta;

   always_comb begin
      if (scan_dn_ff) begin
         scan_res = (scan_y_ff > scan_lim_ff) ? scan_lim_ff : scan_y_ff;
      end else begin
         scan_res = (scan_y_ff < scan_lim_ff) ? scan_lim_ff : scan_y_ff;
      end
   end

   assign run_len  = run_end_ff - py_c;
   assign min_word = cls_ff[3] ? min_len_high_ff : min_len_low_ff;
   assign min_len  = min_word[{cls_ff[2:0], 3'b000} +: 8];
   assign prod     = PROD_W'(run_len[7:0]) * PROD_W'(grid_step_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      col_x_in       = col_x_ff;
      top_in         = top_ff;
      bot_in         = bot_ff;
      run_end_in     = run_end_ff;
      scan_y_in      = scan_y_ff;
      scan_back_in   = scan_back_ff;
      scan_lim_in    = scan_lim_ff;
      scan_dn_in     = scan_dn_ff;
      scan_ret_in    = scan_ret_ff;
      cls_in         = cls_ff;
      py_in          = py_ff;
      xmin_in        = xmin_ff;
      yend_in        = yend_ff;
      ymin_in        = ymin_ff;
      force_in       = force_ff;
      size_in        = size_ff;
      rej_in         = rej_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_rej_in     = rsp_rej_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_run_end_in = rsp_run_end_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_bot_in     = rsp_bot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_EXPLORE)) begin
               cls_in      = req_color_class;
               py_in       = req_pos_y;
               xmin_in     = coord_type'(req_x_left_bound);
               yend_in     = req_y_lower_bound;
               ymin_in     = coord_type'(req_y_upper_bound);
               force_in    = req_force_detailed;
               col_x_in    = coord_type'({{(COORD_W-9){1'b0}}, req_pos_x});
               scan_y_in   = coord_type'({{(COORD_W-8){1'b0}}, req_pos_y}) + skip_c;
               scan_lim_in = coord_type'({{(COORD_W-8){1'b0}}, req_y_lower_bound});
               scan_dn_in  = 1'b1;
               scan_ret_in = RET_RUN;
               state_in    = ST_SC_TEST;
            end
         end
         ST_SC_TEST: begin
            if (scan_dn_ff ? (scan_y_ff < scan_lim_ff) : (scan_y_ff > scan_lim_ff)) begin
               state_in = ST_SC_CHK;
            end else begin
               state_in = ST_SC_DONE;
            end
         end
         ST_SC_CHK: begin
            scan_y_in = y_sum;
            if (pix_match) begin
               state_in = ST_SC_TEST;
            end else begin
               scan_back_in = scan_y_ff - d_skip;
               state_in     = ST_BK_TEST;
            end
         end
         ST_BK_TEST: begin
            if (scan_y_ff != scan_back_ff) begin
               state_in = ST_BK_CHK;
            end else begin
               scan_y_in = y_sum;
               state_in  = ST_SC_DONE;
            end
         end
         ST_BK_CHK: begin
            scan_y_in = y_sum;
            state_in  = pix_match ? ST_SC_TEST : ST_BK_TEST;
         end
         ST_SC_DONE: begin
            case (scan_ret_ff)
               RET_RUN: begin
                  run_end_in = scan_res;
                  state_in   = ST_RUN_POST;
               end
               RET_UP: begin
                  if (scan_res < top_ff) begin
                     top_in = scan_res + coord_type'(1);
                  end
                  state_in = ST_BOT_RD;
               end
               default: begin
                  if (scan_res > bot_ff) begin
                     bot_in = scan_res - coord_type'(1);
                  end
                  col_x_in = col_x_ff - step_c;
                  state_in = ST_COL_TEST;
               end
            endcase
         end
         ST_RUN_POST: begin
            size_in = (run_len > coord_type'(0)) ? prod[11:0] : 12'd0;
            top_in  = py_c;
            rej_in  = 1'b0;
            if ((cls_ff == green_class_ff) && !force_ff) begin
               bot_in   = run_end_ff;
               state_in = ST_FINISH;
            end else begin
               bot_in = run_end_ff - coord_type'(1);
               if (run_len < coord_type'({{(COORD_W-8){1'b0}}, min_len})) begin
                  rej_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  col_x_in = col_x_ff - step_c;
                  state_in = ST_COL_TEST;
               end
            end
         end
         ST_COL_TEST: begin
            state_in = (col_x_ff > xmin_ff) ? ST_TOP_CHK : ST_FINISH;
         end
         ST_TOP_CHK: begin
            if (pix_match) begin
               scan_y_in   = top_ff - skip_c;
               scan_lim_in = ymin_ff;
               scan_dn_in  = 1'b0;
               scan_ret_in = RET_UP;
               state_in    = ST_SC_TEST;
            end else begin
               state_in = ST_BOT_RD;
            end
         end
         ST_BOT_RD: begin
            state_in = ST_BOT_CHK;
         end
         ST_BOT_CHK: begin
            if (pix_match) begin
               scan_y_in   = bot_ff + skip_c;
               scan_lim_in = yend_c;
               scan_dn_in  = 1'b1;
               scan_ret_in = RET_DOWN;
               state_in    = ST_SC_TEST;
            end else begin
               col_x_in = col_x_ff - step_c;
               state_in = ST_COL_TEST;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_rej_in     = rej_ff;
               rsp_size_in    = size_ff;
               rsp_run_end_in = run_end_ff[7:0];
               rsp_top_in     = (top_ff < coord_type'(0)) ? 8'd0 : top_ff[7:0];
               rsp_bot_in     = bot_ff[8:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_x_ff       <= col_x_in;
      top_ff         <= top_in;
      bot_ff         <= bot_in;
      run_end_ff     <= run_end_in;
      scan_y_ff      <= scan_y_in;
      scan_back_ff   <= scan_back_in;
      scan_lim_ff    <= scan_lim_in;
      scan_dn_ff     <= scan_dn_in;
      scan_ret_ff    <= scan_ret_in;
      cls_ff         <= cls_in;
      py_ff          <= py_in;
      xmin_ff        <= xmin_in;
      yend_ff        <= yend_in;
      ymin_ff        <= ymin_in;
      force_ff       <= force_in;
      size_ff        <= size_in;
      rej_ff         <= rej_in;
      rsp_rej_ff     <= rsp_rej_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_run_end_ff <= rsp_run_end_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_bot_ff     <= rsp_bot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_region_size = rsp_size_ff;
   assign rsp_run_end     = rsp_run_end_ff;
   assign rsp_top_y       = rsp_top_ff;
   assign rsp_bottom_y    = rsp_bot_ff;

   // ---------------------------------------------------------------- checks
   a_explore_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == REQ_EXPLORE)) |=> (state_ff == ST_SC_TEST))
      else $error("explore item did not start the run scan");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == REQ_WRITE)) |=> (state_ff == ST_IDLE))
      else $error("write item left the idle state");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finish step");

   a_backtrack_down: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_BK_TEST) && scan_dn_ff) |-> (scan_y_ff >= scan_back_ff))
      else $error("downward backtrack passed its stop row");

   a_backtrack_up: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_BK_TEST) && !scan_dn_ff) |-> (scan_y_ff <= scan_back_ff))
      else $error("upward backtrack passed its stop row");

endmodule
